/* sv/rpfm_pkg.sv */
`timescale 1ns / 1ps

package rpfm_pkg;

  // Frame layout and limits.
  localparam int unsigned FRAME_IDX_W = 7;
  localparam logic [FRAME_IDX_W-1:0] MAX_FRAME_LEN = 7'd64;
  localparam logic [FRAME_IDX_W-1:0] MIN_FRAME_LEN = 7'd6;
  localparam logic [FRAME_IDX_W-1:0] IDX_NONE      = 7'd0;
  localparam logic [FRAME_IDX_W-1:0] IDX_TYPE      = 7'd2;
  localparam logic [FRAME_IDX_W-1:0] IDX_DIST_HI   = 7'd3;
  localparam logic [FRAME_IDX_W-1:0] IDX_DIST_LO   = 7'd4;

  localparam logic [7:0] SYNC_BYTE   = 8'hAA;
  localparam logic [7:0] END_BYTE    = 8'h55;
  localparam logic [7:0] KIND_MICRO  = 8'h02;
  localparam logic [7:0] KIND_MOTION = 8'h01;
  localparam logic [7:0] KIND_EMPTY  = 8'h00;

  localparam logic [31:0] ABSENCE_DELAY_RESET = 32'd5000;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_TOO_SHORT  = 3'd1,
    ST_PRESENCE   = 3'd2,
    ST_ABS_CONFIRM = 3'd3,
    ST_ABS_HELD   = 3'd4,
    ST_IGNORED    = 3'd5
  } status_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    status_t     frame_status;
    logic [15:0] distance_cm;
    logic        presence;
    logic        frame_dropped;
  } out_t;

endpackage

/* sv/radar_presence_frame_monitor.sv */
`timescale 1ns / 1ps

// Channel | Dir | Handshake             | Word
// in      | in  | in_valid / in_ready   | in_t: req_type, rx_byte
// out     | out | out_valid / out_ready | out_t: frame_status, distance_cm, presence,
//         |     |                       |        frame_dropped
// cfg     | in  | cfg_valid / cfg_ready | 32-bit absence_delay_ms
//
// Every input word yields exactly one output word, held in the output register once it is accepted.
// The frame state is updated at the accepting edge and the result lands in the
// output register at the same edge, so one word per cycle is sustained while out_ready is high.
// in_ready stays high while the output register is empty or being drained; a
// stalled output stops intake for as long as out_ready stays low. rst is synchronous
// and clears all control state; absence_delay_ms returns to 5000. cfg is always ready.

module radar_presence_frame_monitor
  import rpfm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  // Architectural state of the frame parser and presence tracker.
  logic [31:0]            absence_delay_ms;
  logic [7:0]             previous_byte;
  logic [FRAME_IDX_W-1:0] frame_index;
  logic [23:0]            captured_fields;
  logic [7:0]             prior_stored_byte;
  logic                   presence_flag;
  logic                   presence_reported;
  logic                   absence_reported;
  logic [31:0]            ms_since_presence;

  logic [7:0]             previous_byte_next;
  logic [FRAME_IDX_W-1:0] frame_index_next;
  logic [23:0]            captured_fields_next;
  logic [7:0]             prior_stored_byte_next;
  logic                   presence_flag_next;
  logic                   presence_reported_next;
  logic                   absence_reported_next;
  logic [31:0]            ms_since_presence_next;
  out_t                   result_next;

  logic                   in_accept;
  logic [FRAME_IDX_W-1:0] stored_len;
  logic                   frame_ends;
  logic [7:0]             kind;

  // The output register is the only buffer; a new word can enter whenever it
  // is empty or its word leaves at this edge.
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    previous_byte_next     = previous_byte;
    frame_index_next       = frame_index;
    captured_fields_next   = captured_fields;
    prior_stored_byte_next = prior_stored_byte;
    presence_flag_next     = presence_flag;
    presence_reported_next = presence_reported;
    absence_reported_next  = absence_reported;
    ms_since_presence_next = ms_since_presence;
    result_next            = '0;
    stored_len             = frame_index + 1'b1;
    frame_ends             = 1'b0;
    kind                   = KIND_EMPTY;

    if (in_data.req_type == REQ_TICK) begin
      // Millisecond tick: the elapsed counter saturates at all ones.
      if (ms_since_presence != '1) begin
        ms_since_presence_next = ms_since_presence + 32'd1;
      end
    end else begin
      previous_byte_next = in_data.rx_byte;
      if (in_data.rx_byte == SYNC_BYTE && previous_byte == SYNC_BYTE) begin
        // Two sync bytes in a row always reopen a frame.
        frame_index_next       = IDX_TYPE;
        captured_fields_next   = '0;
        prior_stored_byte_next = SYNC_BYTE;
      end else if (frame_index != IDX_NONE) begin
        if (frame_index < MAX_FRAME_LEN) begin
          frame_ends = (in_data.rx_byte == END_BYTE) && (prior_stored_byte == END_BYTE);
          case (frame_index)
            IDX_TYPE:    captured_fields_next[23:16] = in_data.rx_byte;
            IDX_DIST_HI: captured_fields_next[15:8]  = in_data.rx_byte;
            IDX_DIST_LO: captured_fields_next[7:0]   = in_data.rx_byte;
            default: ;
          endcase
          frame_index_next       = stored_len;
          prior_stored_byte_next = in_data.rx_byte;
        end else begin
          frame_index_next          = IDX_NONE;
          result_next.frame_dropped = 1'b1;
        end
      end

      // Judge a completed frame by its length and its type byte.
      if (frame_ends) begin
        frame_index_next = IDX_NONE;
        kind             = captured_fields_next[23:16];
        if (stored_len < MIN_FRAME_LEN) begin
          result_next.frame_status = ST_TOO_SHORT;
        end else if ((kind == KIND_MICRO || kind == KIND_MOTION) && !presence_reported) begin
          result_next.frame_status = ST_PRESENCE;
          result_next.distance_cm  = captured_fields_next[15:0];
          ms_since_presence_next   = '0;
          presence_reported_next   = 1'b1;
          presence_flag_next       = 1'b1;
          absence_reported_next    = 1'b0;
        end else if (kind == KIND_EMPTY && !absence_reported) begin
          if (ms_since_presence > absence_delay_ms) begin
            result_next.frame_status = ST_ABS_CONFIRM;
            presence_flag_next       = 1'b0;
            presence_reported_next   = 1'b0;
            absence_reported_next    = 1'b1;
          end else begin
            result_next.frame_status = ST_ABS_HELD;
          end
        end else begin
          result_next.frame_status = ST_IGNORED;
        end
      end
    end

    result_next.presence = presence_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      absence_delay_ms  <= ABSENCE_DELAY_RESET;
      previous_byte     <= '0;
      frame_index       <= IDX_NONE;
      captured_fields   <= '0;
      prior_stored_byte <= '0;
      presence_flag     <= 1'b0;
      presence_reported <= 1'b0;
      absence_reported  <= 1'b0;
      ms_since_presence <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        absence_delay_ms <= cfg_data;
      end
      if (in_accept) begin
        previous_byte     <= previous_byte_next;
        frame_index       <= frame_index_next;
        captured_fields   <= captured_fields_next;
        prior_stored_byte <= prior_stored_byte_next;
        presence_flag     <= presence_flag_next;
        presence_reported <= presence_reported_next;
        absence_reported  <= absence_reported_next;
        ms_since_presence <= ms_since_presence_next;
        out_valid         <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The result word itself needs no reset; out_valid qualifies it.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= result_next;
    end
  end

  // An accepted word always produces a result in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted word produced no result");

  // A presence report always shows the presence flag set.
  a_presence_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_status == ST_PRESENCE |-> out_data.presence)
    else $error("presence reported without presence flag");

  // Confirmed absence always shows the presence flag cleared.
  a_absence_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_status == ST_ABS_CONFIRM |-> !out_data.presence)
    else $error("absence confirmed with presence flag set");

  // A dropped frame never carries a frame verdict or a distance.
  a_drop_no_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_dropped |->
      out_data.frame_status == ST_NONE && out_data.distance_cm == 16'd0)
    else $error("dropped frame carried a verdict");

endmodule
